@@ rtl/server_select_balancer_assert.svh @@
// Assertion macros for the server select balancer.
// Needs clk and rst in the scope of the including module.
`ifndef SERVER_SELECT_BALANCER_ASSERT_SVH
`define SERVER_SELECT_BALANCER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SSB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSB_ASSERT_NOW(label, ante, cons, msg)
`define SSB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/ssb_pkg.sv @@
// Shared types and constants of the server select balancer.
// Used by ssb_div and server_select_balancer; depends on nothing.
package ssb_pkg;

  // actions
  localparam logic [2:0] ACT_REGISTER = 3'd0;
  localparam logic [2:0] ACT_UPDATE   = 3'd1;
  localparam logic [2:0] ACT_REMOVE   = 3'd2;
  localparam logic [2:0] ACT_TICK     = 3'd3;
  localparam logic [2:0] ACT_PICK     = 3'd4;
  localparam logic [2:0] ACT_REBAL    = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NONE     = 3'd2;
  localparam logic [2:0] ST_BALANCED = 3'd3;
  localparam logic [2:0] ST_NO_REBAL = 3'd4;

  // strategies
  localparam logic [1:0] STRAT_RR     = 2'd0;
  localparam logic [1:0] STRAT_FEWEST = 2'd1;

  // config register indexes
  localparam logic [1:0] CFG_STRATEGY = 2'd0;
  localparam logic [1:0] CFG_CPU_LIM  = 2'd1;
  localparam logic [1:0] CFG_MEM_LIM  = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd3;

  // Q8.16 saturation and rebalance threshold (0.3 in Q0.16)
  localparam logic [23:0] Q_MAX       = 24'hFF_FFFF;
  localparam logic [24:0] REBAL_THR   = 25'd19661;
  localparam logic [23:0] LO_RATIO_INIT = 24'd65536;

  // reciprocals: floor(x/5) = x*RECIP_5 >> 26, /125 >> 29, /625 >> 38
  localparam logic [23:0] RECIP_5   = 24'd13421773;
  localparam logic [22:0] RECIP_125 = 23'd4294968;
  localparam logic [28:0] RECIP_625 = 29'd439804652;
  localparam logic [14:0] CPU_SCALE = 15'd24576;

  // one slot of the server table
  typedef struct packed {
    logic [15:0] players;
    logic [15:0] capacity;
    logic [6:0]  cpu_load;
    logic [6:0]  mem_load;
    logic [15:0] latency;
    logic        health;
    logic        accept;
    logic [15:0] age;
  } entry_t;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [15:0] remainder;
  } div_rsp_t;

endpackage

@@ rtl/ssb_div.sv @@
// Bit-serial restoring divider, 32-bit dividend by 16-bit divisor.
// One quotient bit per cycle; depends on ssb_pkg.
module ssb_div
  import ssb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic [5:0]  cnt;
  logic [15:0] rem;
  logic [31:0] quo;
  logic [15:0] dvs;
  logic        done;

  logic [16:0] trial;
  logic        ge;

  // one restoring step
  assign trial = {rem, quo[31]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem  <= ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
        quo  <= {quo[30:0], ge};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

@@ rtl/server_select_balancer.sv @@
// Server select balancer top level: slot table memory and sweep sequencer.
// Depends on ssb_pkg, ssb_div and server_select_balancer_assert.svh.
//
// Keeps SLOTS server entries in a one-port-write, registered-read memory and
// answers one word per request, one request at a time. Register, update,
// remove and unused actions finish without a sweep. Tick, pick and rebalance
// sweep the table one slot at a time; round robin pick sweeps twice, with the
// counter modulo from the divider between the two sweeps. Lowest-score pick
// and rebalance need a load ratio per eligible slot from the bit-serial
// divider. A finished result waits in the output register while the next
// request is taken.
`include "server_select_balancer_assert.svh"
module server_select_balancer
  import ssb_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  action,
  input  logic [3:0]  slot,
  input  logic [15:0] player_count,
  input  logic [15:0] player_cap,
  input  logic [6:0]  cpu_pct,
  input  logic [6:0]  mem_pct,
  input  logic [15:0] ping_ms,
  input  logic        healthy_in,
  input  logic        accepting_in,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [3:0]  chosen_slot,
  output logic [3:0]  target_slot,
  output logic        found,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_EVAL = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_SUM  = 9'b000100000,
    S_NEXT = 9'b001000000,
    S_MOD  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state;

  // config registers
  logic [1:0]  strategy;
  logic [6:0]  cpu_limit;
  logic [6:0]  memory_limit;
  logic [15:0] health_timeout;

  // table state
  logic [SLOTS-1:0] occupied;
  entry_t           mem [SLOTS];
  entry_t           rdata;
  logic             mem_we;
  logic [SW-1:0]    mem_waddr;
  entry_t           mem_wdata;
  logic [31:0]      rr_counter;

  // job registers
  logic [2:0]    act;
  logic [CW-1:0] idx;
  logic          pass2;
  logic [CW-1:0] count;
  logic [CW-1:0] k;
  logic [24:0]   best;
  logic [SW-1:0] chosen;
  logic [SW-1:0] most;
  logic [SW-1:0] least;
  logic          found_r;
  logic          has_max;
  logic          has_min;
  logic [23:0]   hi_ratio;
  logic [23:0]   lo_ratio;
  logic [23:0]   ratio;
  logic [48:0]   p1;
  logic [44:0]   p2;
  logic [44:0]   p3;
  logic [56:0]   p4;
  logic [2:0]    res_status;
  logic [3:0]    res_chosen;
  logic [3:0]    res_target;
  logic          res_found;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  ssb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // request decode
  logic          item_acc;
  logic          in_range;
  logic [SW-1:0] slot_idx;
  logic          occ_hit;
  logic          over_limit;

  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign in_range   = 32'(slot) < SLOTS;
  assign slot_idx   = SW'(slot);
  assign occ_hit    = in_range && occupied[slot_idx];
  assign over_limit = (cpu_pct > cpu_limit) || (mem_pct > memory_limit);
  assign cfg_ready  = 1'b1;

  // current sweep slot
  logic [SW-1:0] cur;
  logic          cur_occ;
  logic          elig;
  logic          last;
  logic          sat;
  logic [15:0]   age_inc;
  logic [22:0]   t1;
  logic [15:0]   t2;
  logic [14:0]   t3;
  logic [18:0]   t4;
  logic [24:0]   score;
  logic [CW-1:0] count_upd;

  assign cur       = idx[SW-1:0];
  assign cur_occ   = occupied[cur];
  assign elig      = cur_occ && rdata.health && rdata.accept;
  assign last      = (idx == CW'(SLOTS - 1));
  assign sat       = {8'd0, rdata.players[15:8]} >= rdata.capacity;
  assign age_inc   = (rdata.age == 16'hFFFF) ? rdata.age : rdata.age + 16'd1;
  assign t1        = p1[48:26];
  assign t2        = p2[44:29];
  assign t3        = p3[43:29];
  assign t4        = p4[56:38];
  assign score     = 25'(t1) + 25'(t2) + 25'(t3) + 25'(t4);
  assign count_upd = count + CW'(elig);

  // memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_idx;
    mem_wdata.players  = player_count;
    mem_wdata.capacity = player_cap;
    mem_wdata.cpu_load = cpu_pct;
    mem_wdata.mem_load = mem_pct;
    mem_wdata.latency  = ping_ms;
    mem_wdata.health   = healthy_in;
    mem_wdata.accept   = accepting_in;
    mem_wdata.age      = '0;
    if (item_acc && action == ACT_REGISTER && in_range) begin
      mem_we = 1'b1;
    end else if (item_acc && action == ACT_UPDATE && occ_hit) begin
      mem_we = 1'b1;
      mem_wdata.accept = accepting_in && !over_limit;
    end else if (state == S_EVAL && act == ACT_TICK && cur_occ) begin
      mem_we           = 1'b1;
      mem_waddr        = cur;
      mem_wdata        = rdata;
      mem_wdata.age    = age_inc;
      mem_wdata.health = rdata.health && !(age_inc > health_timeout);
    end
  end

  // slot table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[cur];
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      strategy       <= 2'd2;
      cpu_limit      <= 7'd90;
      memory_limit   <= 7'd90;
      health_timeout <= 16'd30;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STRATEGY: strategy       <= cfg_data[1:0];
        CFG_CPU_LIM:  cpu_limit      <= cfg_data[6:0];
        CFG_MEM_LIM:  memory_limit   <= cfg_data[6:0];
        CFG_TIMEOUT:  health_timeout <= cfg_data;
        default:      strategy       <= strategy;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      occupied      <= '0;
      rr_counter    <= '0;
      result_valid  <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (result_valid && !result_stall && state != S_FIN) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_acc) begin
            act        <= action;
            idx        <= '0;
            pass2      <= 1'b0;
            count      <= '0;
            found_r    <= 1'b0;
            has_max    <= 1'b0;
            has_min    <= 1'b0;
            hi_ratio   <= '0;
            lo_ratio   <= LO_RATIO_INIT;
            best       <= '0;
            chosen     <= '0;
            most       <= '0;
            least      <= '0;
            res_status <= ST_OK;
            res_chosen <= '0;
            res_target <= '0;
            res_found  <= 1'b0;
            state      <= S_FIN;
            unique case (action)
              ACT_REGISTER: begin
                if (in_range) occupied[slot_idx] <= 1'b1;
                else res_status <= ST_EMPTY;
              end
              ACT_UPDATE: begin
                if (!occ_hit) res_status <= ST_EMPTY;
              end
              ACT_REMOVE: begin
                if (occ_hit) occupied[slot_idx] <= 1'b0;
                else res_status <= ST_EMPTY;
              end
              ACT_TICK: state <= S_LOAD;
              ACT_PICK: begin
                if (|occupied) state <= S_LOAD;
                else res_status <= ST_NONE;
              end
              ACT_REBAL: begin
                if (|occupied) state <= S_LOAD;
                else res_status <= ST_NO_REBAL;
              end
              default: state <= S_FIN;
            endcase
          end
        end

        // read data for idx arrives at this edge
        S_LOAD: state <= S_EVAL;

        S_EVAL: begin
          state <= S_NEXT;
          p2 <= 45'(22'(rdata.cpu_load) * 22'(CPU_SCALE)) * 45'(RECIP_125);
          p3 <= 45'({1'b0, rdata.mem_load, 14'd0}) * 45'(RECIP_125);
          p4 <= 57'({rdata.latency, 12'd0}) * 57'(RECIP_625);
          div_req.dividend <= {rdata.players, 16'd0};
          div_req.divisor  <= rdata.capacity;
          if (act == ACT_PICK) begin
            if (strategy == STRAT_RR) begin
              if (!pass2) begin
                count <= count_upd;
              end else if (elig) begin
                if (k == '0) begin
                  res_chosen <= 4'(cur);
                  res_found  <= 1'b1;
                  state      <= S_FIN;
                end else begin
                  k <= k - CW'(1);
                end
              end
            end else if (strategy == STRAT_FEWEST) begin
              if (elig && (!found_r || 25'(rdata.players) < best)) begin
                best    <= 25'(rdata.players);
                chosen  <= cur;
                found_r <= 1'b1;
              end
            end else if (elig) begin
              if (rdata.capacity == '0) begin
                if (!found_r || 25'(Q_MAX) < best) begin
                  best    <= 25'(Q_MAX);
                  chosen  <= cur;
                  found_r <= 1'b1;
                end
              end else if (sat) begin
                ratio <= Q_MAX;
                state <= S_MUL;
              end else begin
                div_req.start <= 1'b1;
                state         <= S_DIV;
              end
            end
          end else if (act == ACT_REBAL) begin
            if (elig && rdata.capacity != '0) begin
              if (sat) begin
                ratio <= Q_MAX;
                state <= S_SUM;
              end else begin
                div_req.start <= 1'b1;
                state         <= S_DIV;
              end
            end
          end
        end

        S_DIV: begin
          if (div_rsp.done) begin
            ratio <= div_rsp.quotient[23:0];
            state <= (act == ACT_REBAL) ? S_SUM : S_MUL;
          end
        end

        // 0.4 * ratio as ratio*2/5
        S_MUL: begin
          p1    <= 49'({ratio, 1'b0}) * 49'(RECIP_5);
          state <= S_SUM;
        end

        S_SUM: begin
          state <= S_NEXT;
          if (act == ACT_REBAL) begin
            if (ratio > hi_ratio) begin
              hi_ratio <= ratio;
              most     <= cur;
              has_max  <= 1'b1;
            end
            if (ratio < lo_ratio) begin
              lo_ratio <= ratio;
              least    <= cur;
              has_min  <= 1'b1;
            end
          end else if (!found_r || score < best) begin
            best    <= score;
            chosen  <= cur;
            found_r <= 1'b1;
          end
        end

        // advance or close the sweep
        S_NEXT: begin
          if (!last) begin
            idx   <= idx + CW'(1);
            state <= S_LOAD;
          end else begin
            state <= S_FIN;
            if (act == ACT_PICK && strategy == STRAT_RR) begin
              if (!pass2) begin
                if (count == '0) begin
                  res_status <= ST_NONE;
                end else begin
                  div_req.start    <= 1'b1;
                  div_req.dividend <= rr_counter;
                  div_req.divisor  <= 16'(count);
                  state            <= S_MOD;
                end
              end
            end else if (act == ACT_PICK) begin
              res_status <= found_r ? ST_OK : ST_NONE;
              res_chosen <= 4'(chosen);
              res_found  <= found_r;
            end else if (act == ACT_REBAL) begin
              if ({1'b0, hi_ratio} < {1'b0, lo_ratio} + REBAL_THR) begin
                res_status <= ST_BALANCED;
              end else if (!has_max || !has_min) begin
                res_status <= ST_NO_REBAL;
              end else begin
                res_chosen <= 4'(most);
                res_target <= 4'(least);
                res_found  <= 1'b1;
              end
            end
          end
        end

        // round robin index = counter mod eligible count
        S_MOD: begin
          if (div_rsp.done) begin
            k          <= CW'(div_rsp.remainder);
            rr_counter <= rr_counter + 32'd1;
            pass2      <= 1'b1;
            idx        <= '0;
            state      <= S_LOAD;
          end
        end

        S_FIN: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            status       <= res_status;
            chosen_slot  <= res_chosen;
            target_slot  <= res_target;
            found        <= res_found;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `SSB_ASSERT_NEXT(a_busy_after_accept, item_acc, state != S_IDLE, "idle after accept")
  `SSB_ASSERT_NOW(a_div_done_waited, div_rsp.done, state == S_DIV || state == S_MOD, "stray div done")
  `SSB_ASSERT_NOW(a_found_is_ok, result_valid && found, status == ST_OK, "found with bad status")

endmodule
